// ===== design/sobel_prewitt_edge_magnitude_unit_assert.svh =====
// Assertion macros for the edge magnitude design files; only spem_back includes them.
`ifndef SOBEL_PREWITT_EDGE_MAGNITUDE_UNIT_ASSERT_SVH
`define SOBEL_PREWITT_EDGE_MAGNITUDE_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPEM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SPEM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/spem_pkg.sv =====
package spem_pkg;

  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned MAX_HEIGHT = 4096;
  localparam int unsigned MIN_SIZE   = 3;

  localparam int unsigned PIX_W  = 8;
  localparam int unsigned COL_W  = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W  = $clog2(MAX_HEIGHT);
  localparam int unsigned FW_W   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned FH_W   = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned CFG_DATA_W = FH_W;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam int unsigned WIDTH_RESET  = 640;
  localparam int unsigned HEIGHT_RESET = 480;

  localparam int unsigned WIN_SIDE = 3;
  localparam int unsigned WIN_N    = WIN_SIDE * WIN_SIDE;

  localparam int unsigned GRAD_W = PIX_W + 3;
  localparam int unsigned SQ_W   = 2 * GRAD_W - 2;
  localparam int unsigned SUM_W  = SQ_W + 1;
  localparam int unsigned RAD_W  = 2 * PIX_W;

  localparam int unsigned QUEUE_DEPTH = 4;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [WIN_N-1:0][PIX_W-1:0] win_t;

  typedef enum logic {
    ACT_PIXEL = 1'b0,
    ACT_FLUSH = 1'b1
  } action_e;

  typedef enum logic {
    OP_SOBEL   = 1'b0,
    OP_PREWITT = 1'b1
  } op_sel_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OPERATOR_SELECT = 2'd0,
    REG_FRAME_WIDTH     = 2'd1,
    REG_FRAME_HEIGHT    = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_FLUSH = 1'b1
  } cmd_kind_e;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_PIX,
    BK_FL_L,
    BK_FL_M,
    BK_FL_R,
    BK_GRAD,
    BK_SQX,
    BK_SQY,
    BK_ROOT_HI,
    BK_ROOT_LO,
    BK_OUT
  } back_state_e;

  typedef struct packed {
    cmd_kind_e        kind;
    logic [COL_W-1:0] col;
    logic [COL_W-1:0] left;
    logic [COL_W-1:0] right;
    pix_t             pixel;
    logic             row_zero;
    logic             row_one;
    logic             emit_main;
    logic             emit_end;
    logic             frame_end;
  } cmd_t;

endpackage

// ===== design/spem_queue.sv =====
module spem_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  spem_pkg::cmd_t  push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output spem_pkg::cmd_t  pop_data_o,
  output logic            valid_o
);

  localparam int unsigned DEPTH = spem_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  spem_pkg::cmd_t    slot_q [DEPTH];
  logic [PTR_W-1:0]  wptr_q, wptr_d;
  logic [PTR_W-1:0]  rptr_q, rptr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  assign full_o     = (cnt_q == CNT_W'(DEPTH));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = slot_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rptr_d = (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= push_data_i;
    end
  end

endmodule

// ===== design/spem_front.sv =====
module spem_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          action_i,
  input  logic [spem_pkg::PIX_W-1:0]    pixel_i,
  input  logic [spem_pkg::FW_W-1:0]     frame_width_i,
  input  logic [spem_pkg::FH_W-1:0]     frame_height_i,
  input  logic                          q_full_i,
  output logic                          push_o,
  output spem_pkg::cmd_t                cmd_o
);

  localparam int unsigned COL_W = spem_pkg::COL_W;
  localparam int unsigned ROW_W = spem_pkg::ROW_W;
  localparam int unsigned FW_W  = spem_pkg::FW_W;
  localparam int unsigned FH_W  = spem_pkg::FH_W;

  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [FW_W-1:0]  drain_q, drain_d;

  logic [FW_W-1:0]  w_eff;
  logic [FH_W-1:0]  h_eff;
  logic             accept;
  logic             restart;
  logic [COL_W-1:0] c;
  logic [ROW_W-1:0] row;
  logic             row_end;
  logic             row_last;
  logic [COL_W-1:0] x_left;
  logic [COL_W-1:0] x_right;
  logic             drain_last;

  always_comb begin
    if (frame_width_i < FW_W'(spem_pkg::MIN_SIZE)) begin
      w_eff = FW_W'(spem_pkg::MIN_SIZE);
    end else if (frame_width_i > FW_W'(spem_pkg::MAX_WIDTH)) begin
      w_eff = FW_W'(spem_pkg::MAX_WIDTH);
    end else begin
      w_eff = frame_width_i;
    end
    if (frame_height_i < FH_W'(spem_pkg::MIN_SIZE)) begin
      h_eff = FH_W'(spem_pkg::MIN_SIZE);
    end else if (frame_height_i > FH_W'(spem_pkg::MAX_HEIGHT)) begin
      h_eff = FH_W'(spem_pkg::MAX_HEIGHT);
    end else begin
      h_eff = frame_height_i;
    end
  end

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // A pixel that arrives while the last row is still draining starts a new frame.
  assign restart  = (drain_q != '0);
  assign c        = restart ? '0 : col_q;
  assign row      = restart ? '0 : row_q;
  assign row_end  = (FW_W'(c) + FW_W'(1)) >= w_eff;
  assign row_last = (FH_W'(row) + FH_W'(1)) >= h_eff;

  assign x_left     = (col_q == '0) ? '0 : col_q - COL_W'(1);
  assign x_right    = ((FW_W'(col_q) + FW_W'(1)) < w_eff) ? col_q + COL_W'(1) : col_q;
  assign drain_last = (drain_q == FW_W'(1));

  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    drain_d = drain_q;
    push_o  = 1'b0;

    cmd_o.kind      = spem_pkg::CMD_PIXEL;
    cmd_o.col       = c;
    cmd_o.left      = x_left;
    cmd_o.right     = x_right;
    cmd_o.pixel     = pixel_i;
    cmd_o.row_zero  = (row == '0);
    cmd_o.row_one   = (row == ROW_W'(1));
    cmd_o.emit_main = (row != '0) && (c != '0);
    cmd_o.emit_end  = (row != '0) && row_end;
    cmd_o.frame_end = drain_last;

    if (action_i == spem_pkg::ACT_FLUSH) begin
      cmd_o.kind = spem_pkg::CMD_FLUSH;
      cmd_o.col  = col_q;
    end

    if (accept) begin
      if (action_i == spem_pkg::ACT_PIXEL) begin
        push_o  = 1'b1;
        drain_d = '0;
        row_d   = row;
        if (row_end) begin
          col_d = '0;
          if (row_last) begin
            row_d   = '0;
            drain_d = w_eff;
          end else begin
            row_d = row + ROW_W'(1);
          end
        end else begin
          col_d = c + COL_W'(1);
        end
      end else if (drain_q != '0) begin
        push_o  = 1'b1;
        drain_d = drain_q - FW_W'(1);
        col_d   = drain_last ? '0 : col_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      drain_q <= '0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      drain_q <= drain_d;
    end
  end

endmodule

// ===== design/spem_back.sv =====
`include "sobel_prewitt_edge_magnitude_unit_assert.svh"

module spem_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cmd_valid_i,
  input  spem_pkg::cmd_t              cmd_i,
  output logic                        cmd_pop_o,
  input  logic                        op_sel_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [spem_pkg::PIX_W-1:0]  magnitude_o,
  output logic                        frame_end_o,
  output logic                        last_o
);

  localparam int unsigned PIX_W  = spem_pkg::PIX_W;
  localparam int unsigned COL_W  = spem_pkg::COL_W;
  localparam int unsigned GRAD_W = spem_pkg::GRAD_W;
  localparam int unsigned SQ_W   = spem_pkg::SQ_W;
  localparam int unsigned SUM_W  = spem_pkg::SUM_W;
  localparam int unsigned RAD_W  = spem_pkg::RAD_W;
  localparam int unsigned LS_W   = 2 * PIX_W;
  localparam int unsigned SIDE   = spem_pkg::WIN_SIDE;

  typedef struct packed {
    logic [RAD_W-1:0] num;
    logic [RAD_W-1:0] res;
  } root_t;

  function automatic logic signed [GRAD_W-1:0] pdiff(input spem_pkg::pix_t p,
                                                     input spem_pkg::pix_t q);
    return $signed(GRAD_W'(p)) - $signed(GRAD_W'(q));
  endfunction

  // Window seen by the right border: column W copies column W-1.
  function automatic spem_pkg::win_t right_edge(input spem_pkg::win_t w);
    spem_pkg::win_t p;
    for (int i = 0; i < SIDE; i++) begin
      p[i*SIDE]     = w[i*SIDE+1];
      p[i*SIDE + 1] = w[i*SIDE+2];
      p[i*SIDE + 2] = w[i*SIDE+2];
    end
    return p;
  endfunction

  // Four digits of the bitwise integer square root; the upper half runs first.
  function automatic root_t root_steps(input root_t st, input logic upper);
    root_t            r;
    logic [RAD_W-1:0] bitv;
    logic [RAD_W:0]   trial;
    r = st;
    for (int i = 0; i < 4; i++) begin
      bitv  = RAD_W'(1) << (upper ? (RAD_W - 2 - 2 * i) : (RAD_W / 2 - 2 - 2 * i));
      trial = {1'b0, r.res} + {1'b0, bitv};
      if ({1'b0, r.num} >= trial) begin
        r.num = r.num - trial[RAD_W-1:0];
        r.res = (r.res >> 1) + bitv;
      end else begin
        r.res = r.res >> 1;
      end
    end
    return r;
  endfunction

  spem_pkg::back_state_e state_q, state_d;
  spem_pkg::cmd_t        cmd_q, cmd_d;

  logic [LS_W-1:0]   ls_mem [spem_pkg::MAX_WIDTH];
  logic [LS_W-1:0]   ls_rdata_q;
  logic              ls_rd_en;
  logic [COL_W-1:0]  ls_rd_addr;
  logic              ls_wr_en;

  spem_pkg::win_t    window_q, window_d;
  spem_pkg::win_t    kern_q, kern_d;
  spem_pkg::win_t    win_new;
  spem_pkg::pix_t    col_v [SIDE];
  spem_pkg::pix_t    pix_a;
  spem_pkg::pix_t    pix_b;

  logic signed [GRAD_W-1:0]   gx_q, gx_d, gy_q, gy_d;
  logic signed [GRAD_W-1:0]   gx_mid, gy_mid, gx_c, gy_c;
  logic signed [GRAD_W-1:0]   sq_in;
  logic signed [2*GRAD_W-1:0] sq_prod;
  logic [SQ_W-1:0]            sqx_q, sqx_d;
  logic [SUM_W-1:0]           sum;
  logic                       sat_q, sat_d;
  root_t                      root_q, root_d, root_next;

  logic [PIX_W-1:0] mag_q, mag_d;
  logic             fend_q, fend_d;
  logic             last_q, last_d;
  logic             second_q, second_d;

  always_ff @(posedge clk_i) begin
    if (ls_wr_en) begin
      ls_mem[cmd_q.col] <= {cmd_q.pixel, pix_b};
    end
    if (ls_rd_en) begin
      ls_rdata_q <= ls_mem[ls_rd_addr];
    end
  end

  // The upper byte holds the previous row, the lower byte the row before it.
  assign pix_b = cmd_q.row_zero ? cmd_q.pixel : ls_rdata_q[LS_W-1:PIX_W];
  assign pix_a = cmd_q.row_zero ? cmd_q.pixel :
                 (cmd_q.row_one ? pix_b : ls_rdata_q[PIX_W-1:0]);

  assign col_v[0] = pix_a;
  assign col_v[1] = pix_b;
  assign col_v[2] = cmd_q.pixel;

  always_comb begin
    for (int i = 0; i < SIDE; i++) begin
      if (cmd_q.col == '0) begin
        win_new[i*SIDE]     = col_v[i];
        win_new[i*SIDE + 1] = col_v[i];
      end else begin
        win_new[i*SIDE]     = window_q[i*SIDE+1];
        win_new[i*SIDE + 1] = window_q[i*SIDE+2];
      end
      win_new[i*SIDE + 2] = col_v[i];
    end
  end

  assign gx_mid = pdiff(kern_q[5], kern_q[3]);
  assign gy_mid = pdiff(kern_q[7], kern_q[1]);
  assign gx_c   = pdiff(kern_q[2], kern_q[0])
                + ((op_sel_i == spem_pkg::OP_PREWITT) ? gx_mid : (gx_mid <<< 1))
                + pdiff(kern_q[8], kern_q[6]);
  assign gy_c   = pdiff(kern_q[6], kern_q[0])
                + ((op_sel_i == spem_pkg::OP_PREWITT) ? gy_mid : (gy_mid <<< 1))
                + pdiff(kern_q[8], kern_q[2]);

  assign sq_in     = (state_q == spem_pkg::BK_SQX) ? gx_q : gy_q;
  assign sq_prod   = (2*GRAD_W)'(sq_in) * (2*GRAD_W)'(sq_in);
  assign sum       = {1'b0, sqx_q} + {1'b0, sq_prod[SQ_W-1:0]};
  assign root_next = root_steps(root_q, state_q == spem_pkg::BK_ROOT_HI);

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    window_d   = window_q;
    kern_d     = kern_q;
    gx_d       = gx_q;
    gy_d       = gy_q;
    sqx_d      = sqx_q;
    sat_d      = sat_q;
    root_d     = root_q;
    mag_d      = mag_q;
    fend_d     = fend_q;
    last_d     = last_q;
    second_d   = second_q;
    cmd_pop_o  = 1'b0;
    ls_rd_en   = 1'b0;
    ls_rd_addr = cmd_q.col;
    ls_wr_en   = 1'b0;

    case (state_q)
      spem_pkg::BK_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          ls_rd_en  = 1'b1;
          if (cmd_i.kind == spem_pkg::CMD_PIXEL) begin
            ls_rd_addr = cmd_i.col;
            state_d    = spem_pkg::BK_PIX;
          end else begin
            ls_rd_addr = cmd_i.left;
            state_d    = spem_pkg::BK_FL_L;
          end
        end
      end
      spem_pkg::BK_PIX: begin
        ls_wr_en = 1'b1;
        window_d = win_new;
        fend_d   = 1'b0;
        if (cmd_q.emit_main) begin
          kern_d   = win_new;
          second_d = cmd_q.emit_end;
          last_d   = !cmd_q.emit_end;
          state_d  = spem_pkg::BK_GRAD;
        end else if (cmd_q.emit_end) begin
          kern_d   = right_edge(win_new);
          second_d = 1'b0;
          last_d   = 1'b1;
          state_d  = spem_pkg::BK_GRAD;
        end else begin
          state_d = spem_pkg::BK_IDLE;
        end
      end
      spem_pkg::BK_FL_L: begin
        kern_d[0]  = ls_rdata_q[PIX_W-1:0];
        kern_d[3]  = ls_rdata_q[LS_W-1:PIX_W];
        kern_d[6]  = ls_rdata_q[LS_W-1:PIX_W];
        ls_rd_en   = 1'b1;
        ls_rd_addr = cmd_q.col;
        state_d    = spem_pkg::BK_FL_M;
      end
      spem_pkg::BK_FL_M: begin
        kern_d[1]  = ls_rdata_q[PIX_W-1:0];
        kern_d[4]  = ls_rdata_q[LS_W-1:PIX_W];
        kern_d[7]  = ls_rdata_q[LS_W-1:PIX_W];
        ls_rd_en   = 1'b1;
        ls_rd_addr = cmd_q.right;
        state_d    = spem_pkg::BK_FL_R;
      end
      spem_pkg::BK_FL_R: begin
        kern_d[2] = ls_rdata_q[PIX_W-1:0];
        kern_d[5] = ls_rdata_q[LS_W-1:PIX_W];
        kern_d[8] = ls_rdata_q[LS_W-1:PIX_W];
        second_d  = 1'b0;
        last_d    = 1'b1;
        fend_d    = cmd_q.frame_end;
        state_d   = spem_pkg::BK_GRAD;
      end
      spem_pkg::BK_GRAD: begin
        gx_d    = gx_c;
        gy_d    = gy_c;
        state_d = spem_pkg::BK_SQX;
      end
      spem_pkg::BK_SQX: begin
        sqx_d   = sq_prod[SQ_W-1:0];
        state_d = spem_pkg::BK_SQY;
      end
      spem_pkg::BK_SQY: begin
        sat_d      = |sum[SUM_W-1:RAD_W];
        root_d.num = sum[RAD_W-1:0];
        root_d.res = '0;
        state_d    = spem_pkg::BK_ROOT_HI;
      end
      spem_pkg::BK_ROOT_HI: begin
        root_d  = root_next;
        state_d = spem_pkg::BK_ROOT_LO;
      end
      spem_pkg::BK_ROOT_LO: begin
        mag_d   = sat_q ? {PIX_W{1'b1}} : root_next.res[PIX_W-1:0];
        state_d = spem_pkg::BK_OUT;
      end
      spem_pkg::BK_OUT: begin
        if (out_ready_i) begin
          if (second_q) begin
            kern_d   = right_edge(window_q);
            second_d = 1'b0;
            last_d   = 1'b1;
            state_d  = spem_pkg::BK_GRAD;
          end else begin
            state_d = spem_pkg::BK_IDLE;
          end
        end
      end
      default: begin
        state_d = spem_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= spem_pkg::BK_IDLE;
      second_q <= 1'b0;
      for (int i = 0; i < spem_pkg::WIN_N; i++) begin
        window_q[i] <= '0;
      end
    end else begin
      state_q  <= state_d;
      second_q <= second_d;
      window_q <= window_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    kern_q <= kern_d;
    gx_q   <= gx_d;
    gy_q   <= gy_d;
    sqx_q  <= sqx_d;
    sat_q  <= sat_d;
    root_q <= root_d;
    mag_q  <= mag_d;
    fend_q <= fend_d;
    last_q <= last_d;
  end

  assign out_valid_o = (state_q == spem_pkg::BK_OUT);
  assign magnitude_o = mag_q;
  assign frame_end_o = fend_q;
  assign last_o      = last_q;

  `SPEM_ASSERT_IMP(a_fend_is_last, clk_i, rst_ni, out_valid_o && frame_end_o, last_o, "frame end word is not the last word of its item")
  `SPEM_ASSERT_IMP(a_flush_single, clk_i, rst_ni, out_valid_o && (cmd_q.kind == spem_pkg::CMD_FLUSH), last_o && !second_q, "flush item gives more than one word")
  `SPEM_ASSERT_NXT(a_pop_starts, clk_i, rst_ni, cmd_pop_o, (state_q == spem_pkg::BK_PIX) || (state_q == spem_pkg::BK_FL_L), "popped command did not start")
  `SPEM_ASSERT_NXT(a_second_word, clk_i, rst_ni, out_valid_o && out_ready_i && second_q, (state_q == spem_pkg::BK_GRAD) && last_q && !second_q, "row end word was not issued")

endmodule

// ===== design/sobel_prewitt_edge_magnitude_unit.sv =====
// A pixel word that gives an output runs through PIX, GRAD, SQX, SQY, ROOT_HI, ROOT_LO and OUT;
// a flush reads the line store in FL_L, FL_M, FL_R instead of PIX. One shared magnitude datapath
// (gradient, squares, two root steps) serves one command at a time and waits in OUT on out_ready.
// A 4-entry command queue lets the input side keep accepting words while a result waits.
// Reset (rst_ni, asynchronous, active low) clears counters, window, queue and sequencer;
// the line store is not cleared and needs no clearing pass.
module sobel_prewitt_edge_magnitude_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               action_i,
  input  logic [spem_pkg::PIX_W-1:0]         pixel_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [spem_pkg::PIX_W-1:0]         magnitude_o,
  output logic                               frame_end_o,
  output logic                               last_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [spem_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [spem_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  logic                          op_sel_q;
  logic [spem_pkg::FW_W-1:0]     frame_width_q;
  logic [spem_pkg::FH_W-1:0]     frame_height_q;

  logic            q_full;
  logic            push;
  spem_pkg::cmd_t  push_cmd;
  logic            q_valid;
  spem_pkg::cmd_t  pop_cmd;
  logic            pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_sel_q       <= spem_pkg::OP_SOBEL;
      frame_width_q  <= spem_pkg::FW_W'(spem_pkg::WIDTH_RESET);
      frame_height_q <= spem_pkg::FH_W'(spem_pkg::HEIGHT_RESET);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (spem_pkg::cfg_reg_e'(cfg_index_i))
        spem_pkg::REG_OPERATOR_SELECT: begin
          op_sel_q <= cfg_data_i[0];
        end
        spem_pkg::REG_FRAME_WIDTH: begin
          frame_width_q <= cfg_data_i[spem_pkg::FW_W-1:0];
        end
        spem_pkg::REG_FRAME_HEIGHT: begin
          frame_height_q <= cfg_data_i[spem_pkg::FH_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  spem_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .action_i       (action_i),
    .pixel_i        (pixel_i),
    .frame_width_i  (frame_width_q),
    .frame_height_i (frame_height_q),
    .q_full_i       (q_full),
    .push_o         (push),
    .cmd_o          (push_cmd)
  );

  spem_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (q_full),
    .pop_i       (pop),
    .pop_data_o  (pop_cmd),
    .valid_o     (q_valid)
  );

  spem_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (pop_cmd),
    .cmd_pop_o   (pop),
    .op_sel_i    (op_sel_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .magnitude_o (magnitude_o),
    .frame_end_o (frame_end_o),
    .last_o      (last_o)
  );

endmodule

// ===== bench/sobel_prewitt_edge_magnitude_unit_tb.sv =====
`timescale 1ns / 1ps

module sobel_prewitt_edge_magnitude_unit_tb;
  import spem_pkg::*;

  typedef struct packed {
    pix_t mag;
    logic fe;
    logic last;
  } px_word_t;

  typedef struct packed {
    action_e  act;
    pix_t     pix;
    op_sel_e  op;
    logic     typed;
    logic [1:0] n;
    pix_t     m0;
    logic     f0;
    pix_t     m1;
    logic     f1;
  } stim_row_t;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  action_e in_action = ACT_PIXEL;
  pix_t in_pixel = '0;
  logic out_ready = 1'b0;
  logic cfg_valid = 1'b0;
  cfg_reg_e cfg_index = REG_OPERATOR_SELECT;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic in_ready;
  logic out_valid;
  pix_t mag_out;
  logic fend_out;
  logic last_out;
  logic cfg_ready;

  // Filter state mirrored on the bench side.
  pix_t f_store [2*MAX_WIDTH];
  win_t f_win;
  int unsigned f_col = 0;
  int unsigned f_row = 0;
  int unsigned f_drain = 0;
  op_sel_e f_op = OP_SOBEL;
  logic [FW_W-1:0] f_width_reg = FW_W'(WIDTH_RESET);
  logic [FH_W-1:0] f_height_reg = FH_W'(HEIGHT_RESET);

  px_word_t fresh_words[$];
  px_word_t due_words[$];

  int unsigned mismatches = 0;
  int unsigned words_sent = 0;
  int unsigned flushes_sent = 0;
  int unsigned words_checked = 0;
  int unsigned frame_ends = 0;
  int unsigned cfg_writes = 0;
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;
  int rx_holdoff = 0;

  stim_row_t dir_tab [25] = '{
    '{ACT_FLUSH, 8'd0,   OP_SOBEL,   1'b1, 2'd0, 8'd0,   1'b0, 8'd0,   1'b0},
    '{ACT_PIXEL, 8'd0,   OP_SOBEL,   1'b1, 2'd0, 8'd0,   1'b0, 8'd0,   1'b0},
    '{ACT_PIXEL, 8'd0,   OP_SOBEL,   1'b1, 2'd0, 8'd0,   1'b0, 8'd0,   1'b0},
    '{ACT_PIXEL, 8'd0,   OP_SOBEL,   1'b1, 2'd0, 8'd0,   1'b0, 8'd0,   1'b0},
    '{ACT_PIXEL, 8'd255, OP_SOBEL,   1'b1, 2'd0, 8'd0,   1'b0, 8'd0,   1'b0},
    '{ACT_PIXEL, 8'd255, OP_SOBEL,   1'b1, 2'd1, 8'd255, 1'b0, 8'd0,   1'b0},
    '{ACT_PIXEL, 8'd255, OP_SOBEL,   1'b1, 2'd2, 8'd255, 1'b0, 8'd255, 1'b0},
    '{ACT_PIXEL, 8'd255, OP_SOBEL,   1'b1, 2'd0, 8'd0,   1'b0, 8'd0,   1'b0},
    '{ACT_PIXEL, 8'd255, OP_SOBEL,   1'b1, 2'd1, 8'd255, 1'b0, 8'd0,   1'b0},
    '{ACT_PIXEL, 8'd255, OP_SOBEL,   1'b1, 2'd2, 8'd255, 1'b0, 8'd255, 1'b0},
    '{ACT_FLUSH, 8'd0,   OP_SOBEL,   1'b1, 2'd1, 8'd0,   1'b0, 8'd0,   1'b0},
    '{ACT_FLUSH, 8'd255, OP_SOBEL,   1'b1, 2'd1, 8'd0,   1'b0, 8'd0,   1'b0},
    '{ACT_FLUSH, 8'd0,   OP_SOBEL,   1'b1, 2'd1, 8'd0,   1'b1, 8'd0,   1'b0},
    '{ACT_FLUSH, 8'd0,   OP_SOBEL,   1'b1, 2'd0, 8'd0,   1'b0, 8'd0,   1'b0},
    '{ACT_PIXEL, 8'd0,   OP_PREWITT, 1'b0, 2'd0, 8'd0,   1'b0, 8'd0,   1'b0},
    '{ACT_PIXEL, 8'd255, OP_PREWITT, 1'b0, 2'd0, 8'd0,   1'b0, 8'd0,   1'b0},
    '{ACT_PIXEL, 8'd0,   OP_PREWITT, 1'b0, 2'd0, 8'd0,   1'b0, 8'd0,   1'b0},
    '{ACT_PIXEL, 8'd255, OP_PREWITT, 1'b0, 2'd0, 8'd0,   1'b0, 8'd0,   1'b0},
    '{ACT_PIXEL, 8'd0,   OP_PREWITT, 1'b0, 2'd0, 8'd0,   1'b0, 8'd0,   1'b0},
    '{ACT_PIXEL, 8'd255, OP_PREWITT, 1'b0, 2'd0, 8'd0,   1'b0, 8'd0,   1'b0},
    '{ACT_PIXEL, 8'd17,  OP_PREWITT, 1'b0, 2'd0, 8'd0,   1'b0, 8'd0,   1'b0},
    '{ACT_PIXEL, 8'd200, OP_PREWITT, 1'b0, 2'd0, 8'd0,   1'b0, 8'd0,   1'b0},
    '{ACT_PIXEL, 8'd90,  OP_PREWITT, 1'b0, 2'd0, 8'd0,   1'b0, 8'd0,   1'b0},
    '{ACT_FLUSH, 8'd0,   OP_PREWITT, 1'b0, 2'd0, 8'd0,   1'b0, 8'd0,   1'b0},
    '{ACT_PIXEL, 8'd128, OP_PREWITT, 1'b0, 2'd0, 8'd0,   1'b0, 8'd0,   1'b0}
  };

  sobel_prewitt_edge_magnitude_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .action_i    (in_action),
    .pixel_i     (in_pixel),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .magnitude_o (mag_out),
    .frame_end_o (fend_out),
    .last_o      (last_out),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic int unsigned eff_w();
    if (f_width_reg < MIN_SIZE) return MIN_SIZE;
    if (f_width_reg > MAX_WIDTH) return MAX_WIDTH;
    return f_width_reg;
  endfunction

  function automatic int unsigned eff_h();
    if (f_height_reg < MIN_SIZE) return MIN_SIZE;
    if (f_height_reg > MAX_HEIGHT) return MAX_HEIGHT;
    return f_height_reg;
  endfunction

  function automatic pix_t grad_mag(win_t p);
    int k;
    int gx;
    int gy;
    int unsigned s;
    int unsigned root;
    int unsigned t;
    int b;
    k = (f_op == OP_PREWITT) ? 1 : 2;
    gx = (int'(p[2]) - int'(p[0])) + k * (int'(p[5]) - int'(p[3]))
       + (int'(p[8]) - int'(p[6]));
    gy = (int'(p[6]) - int'(p[0])) + k * (int'(p[7]) - int'(p[1]))
       + (int'(p[8]) - int'(p[2]));
    s = gx * gx + gy * gy;
    if (s >= 65536) return '1;
    root = 0;
    for (b = 7; b >= 0; b--) begin
      t = root | (32'd1 << b);
      if (t * t <= s) root = t;
    end
    return pix_t'(root);
  endfunction

  function automatic void filter_step(action_e a, pix_t px);
    int unsigned w;
    int unsigned h;
    int unsigned x;
    int unsigned l;
    int unsigned r;
    int unsigned c;
    int i;
    pix_t va;
    pix_t vb;
    pix_t v;
    win_t nb;
    w = eff_w();
    h = eff_h();
    fresh_words.delete();
    if (a == ACT_FLUSH) begin
      if (f_drain != 0) begin
        x = f_col % MAX_WIDTH;
        l = (x > 0) ? x - 1 : 0;
        r = (x + 1 < w) ? x + 1 : x;
        nb[0] = f_store[l];
        nb[1] = f_store[x];
        nb[2] = f_store[r];
        nb[3] = f_store[MAX_WIDTH + l];
        nb[4] = f_store[MAX_WIDTH + x];
        nb[5] = f_store[MAX_WIDTH + r];
        nb[6] = nb[3];
        nb[7] = nb[4];
        nb[8] = nb[5];
        f_drain--;
        f_col++;
        fresh_words.push_back('{mag: grad_mag(nb), fe: (f_drain == 0), last: 1'b1});
        if (f_drain == 0) f_col = 0;
      end
    end else begin
      if (f_drain != 0) begin
        f_drain = 0;
        f_col = 0;
        f_row = 0;
      end
      c = f_col % MAX_WIDTH;
      if (f_row == 0) begin
        va = px;
        vb = px;
      end else begin
        vb = f_store[MAX_WIDTH + c];
        va = (f_row == 1) ? vb : f_store[c];
      end
      f_store[c] = vb;
      f_store[MAX_WIDTH + c] = px;
      for (i = 0; i < 3; i++) begin
        v = (i == 0) ? va : (i == 1) ? vb : px;
        if (c == 0) begin
          f_win[i*3] = v;
          f_win[i*3+1] = v;
        end else begin
          f_win[i*3] = f_win[i*3+1];
          f_win[i*3+1] = f_win[i*3+2];
        end
        f_win[i*3+2] = v;
      end
      if (f_row >= 1) begin
        if (c >= 1) fresh_words.push_back('{mag: grad_mag(f_win), fe: 1'b0, last: 1'b0});
        if (c + 1 >= w) begin
          for (i = 0; i < 3; i++) begin
            nb[i*3] = f_win[i*3+1];
            nb[i*3+1] = f_win[i*3+2];
            nb[i*3+2] = f_win[i*3+2];
          end
          fresh_words.push_back('{mag: grad_mag(nb), fe: 1'b0, last: 1'b0});
        end
      end
      if (c + 1 >= w) begin
        f_col = 0;
        if (f_row + 1 >= h) begin
          f_row = 0;
          f_drain = w;
        end else begin
          f_row = f_row + 1;
        end
      end else begin
        f_col = c + 1;
      end
      if (fresh_words.size() > 0) fresh_words[fresh_words.size()-1].last = 1'b1;
    end
  endfunction

  function automatic pix_t rand_pix();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return pix_t'($urandom_range(0, 255));
  endfunction

  function automatic stim_row_t free_word(action_e a, pix_t p);
    stim_row_t s;
    s = '0;
    s.act = a;
    s.pix = p;
    s.op = f_op;
    return s;
  endfunction

  task automatic log_mismatch(string what);
    mismatches++;
    if (mismatches <= 30) $display("[%0t] MISMATCH %s", $time, what);
  endtask

  task automatic send_word(stim_row_t s);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_action <= s.act;
    in_pixel <= s.pix;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    filter_step(s.act, s.pix);
    words_sent++;
    if (s.act == ACT_FLUSH) flushes_sent++;
    if (s.typed) begin
      if (s.n > 0) due_words.push_back('{mag: s.m0, fe: s.f0, last: (s.n == 2'd1)});
      if (s.n > 1) due_words.push_back('{mag: s.m1, fe: s.f1, last: 1'b1});
    end else begin
      foreach (fresh_words[i]) due_words.push_back(fresh_words[i]);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (due_words.size() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);
  endtask

  task automatic set_config(logic [CFG_DATA_W-1:0] op_d, logic [CFG_DATA_W-1:0] w_d,
                            logic [CFG_DATA_W-1:0] h_d);
    logic [CFG_DATA_W-1:0] vals [3];
    int k;
    vals[0] = op_d;
    vals[1] = w_d;
    vals[2] = h_d;
    cfg_valid <= 1'b1;
    for (k = 0; k < 3; k++) begin
      cfg_index <= cfg_reg_e'(k);
      cfg_data <= vals[k];
      @(posedge clk_i);
      while (!cfg_ready) @(posedge clk_i);
      case (cfg_reg_e'(k))
        REG_OPERATOR_SELECT: f_op = op_sel_e'(vals[k][0]);
        REG_FRAME_WIDTH:     f_width_reg = vals[k][FW_W-1:0];
        REG_FRAME_HEIGHT:    f_height_reg = vals[k][FH_W-1:0];
        default: ;
      endcase
      cfg_writes++;
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin : drain_side
    int g;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (rx_holdoff > 0) begin
        g = rx_holdoff;
        rx_holdoff = 0;
      end else begin
        g = rx_steady ? 0 : $urandom_range(0, 7);
      end
      if (g > 0) begin
        out_ready <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      @(posedge clk_i);
      while (!out_valid) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin : out_check
    px_word_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (due_words.size() == 0) begin
        log_mismatch($sformatf("result word with none due, magnitude %0d", mag_out));
      end else begin
        want = due_words.pop_front();
        words_checked++;
        if (want.fe) frame_ends++;
        if (mag_out !== want.mag)
          log_mismatch($sformatf("magnitude %0d, want %0d", mag_out, want.mag));
        if (fend_out !== want.fe)
          log_mismatch($sformatf("frame_end %b, want %b", fend_out, want.fe));
        if (last_out !== want.last)
          log_mismatch($sformatf("last %b, want %b", last_out, want.last));
      end
    end
  end

  initial begin : stimulus
    stim_row_t s;
    int ph;
    int n;
    int k;
    int sel;
    int spins;
    action_e act;
    logic [CFG_DATA_W-1:0] op_d;
    logic [CFG_DATA_W-1:0] w_d;
    logic [CFG_DATA_W-1:0] h_d;
    foreach (f_win[i]) f_win[i] = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_config(13'd0, 13'd3, 13'd3);
    foreach (dir_tab[i]) begin
      s = dir_tab[i];
      if (s.op != f_op) begin
        settle();
        set_config({12'd0, s.op}, 13'd3, 13'd3);
      end
      send_word(s);
    end

    // The first row of a full-width frame writes every column of both line stores,
    // so later size changes in the middle of a frame never read stale entries.
    settle();
    set_config(13'd0, 13'd1024, 13'd4096);
    for (k = 0; k < 1023 + 6; k++) send_word(free_word(ACT_PIXEL, rand_pix()));
    settle();
    set_config(13'd1, 13'd5, 13'd3);
    send_word(free_word(ACT_PIXEL, rand_pix()));

    for (ph = 0; ph < 12; ph++) begin
      settle();
      op_d = 13'($urandom_range(0, 8191));
      sel = $urandom_range(0, 9);
      w_d = (sel == 0) ? 13'($urandom_range(0, 2)) :
            (sel == 1) ? 13'($urandom_range(0, 8191)) : 13'($urandom_range(3, 10));
      sel = $urandom_range(0, 9);
      h_d = (sel == 0) ? 13'($urandom_range(0, 2)) :
            (sel == 1) ? 13'($urandom_range(0, 8191)) : 13'($urandom_range(3, 6));
      if (ph == 3) w_d = 13'd4;
      set_config(op_d, w_d, h_d);
      tx_steady = (ph % 4 == 1) || (ph == 3);
      rx_steady = (ph % 4 == 2);
      if (ph == 3) rx_holdoff = 400;
      n = $urandom_range(60, 80);
      for (k = 0; k < n; k++) begin
        if (ph == 5 && k == n / 2) begin
          in_valid <= 1'b0;
          @(posedge clk_i);
          while (due_words.size() != 0) @(posedge clk_i);
        end
        if (f_drain != 0) act = ($urandom_range(0, 99) < 88) ? ACT_FLUSH : ACT_PIXEL;
        else act = ($urandom_range(0, 99) < 6) ? ACT_FLUSH : ACT_PIXEL;
        send_word(free_word(act, rand_pix()));
      end
    end

    in_valid <= 1'b0;
    spins = 0;
    while (due_words.size() != 0 && spins < 50000) begin
      @(posedge clk_i);
      spins++;
    end
    repeat (64) @(posedge clk_i);
    if (due_words.size() != 0)
      log_mismatch($sformatf("%0d result words never arrived", due_words.size()));
    $display("Sent %0d input words (%0d flushes) and checked %0d result words, %0d frame ends.",
             words_sent, flushes_sent, words_checked, frame_ends);
    $display("Made %0d register writes: both kernels, sizes 3x3 to 1024x4096, clamped values.",
             cfg_writes);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
